// File: rtl/sha512_pkg.sv
// sha512_pkg: shared types, constants and round functions of the sha-512 engine
// holds the round constant table, initial hash values and the control enums
// depends on nothing; imported by the engine top level
package sha512_pkg;

    localparam int WORD_W     = 64;
    localparam int NB_W       = 4;
    localparam int BLK_DEPTH  = 16;
    localparam int HASH_DEPTH = 8;
    localparam int ROUNDS     = 80;

    // byte count of a full message word
    localparam logic [NB_W-1:0] FULL_BYTES = 4'd8;
    // block slot that holds the high length word
    localparam logic [3:0]      LEN_SLOT   = 4'd14;
    localparam logic [7:0]      MARK_BYTE  = 8'h80;
    localparam logic [6:0]      LAST_ROUND = 7'd79;
    localparam logic [6:0]      LOAD_END   = 7'd8;
    localparam logic [2:0]      LAST_IDX   = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        PH_NONE,
        PH_MSG,
        PH_MARK,
        PH_ZERO,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_DONE
    } phase_t;

    function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] big_sigma0(input logic [63:0] x);
        return ror64(x, 28) ^ ror64(x, 34) ^ ror64(x, 39);
    endfunction

    function automatic logic [63:0] big_sigma1(input logic [63:0] x);
        return ror64(x, 14) ^ ror64(x, 18) ^ ror64(x, 41);
    endfunction

    function automatic logic [63:0] small_sigma0(input logic [63:0] x);
        return ror64(x, 1) ^ ror64(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] small_sigma1(input logic [63:0] x);
        return ror64(x, 19) ^ ror64(x, 61) ^ (x >> 6);
    endfunction

    // closing word: nb message bytes kept, then the pad marker, then zeros
    function automatic logic [63:0] mark_word(input logic [63:0] msg, input logic [2:0] nb);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < int'(nb)) begin
                w[63-8*i -: 8] = msg[63-8*i -: 8];
            end else if (i == int'(nb)) begin
                w[63-8*i -: 8] = MARK_BYTE;
            end
        end
        return w;
    endfunction

    function automatic logic [63:0] init_h(input logic [2:0] idx);
        logic [63:0] v;
        case (idx)
            3'd0:    v = 64'h6a09e667f3bcc908;
            3'd1:    v = 64'hbb67ae8584caa73b;
            3'd2:    v = 64'h3c6ef372fe94f82b;
            3'd3:    v = 64'ha54ff53a5f1d36f1;
            3'd4:    v = 64'h510e527fade682d1;
            3'd5:    v = 64'h9b05688c2b3e6c1f;
            3'd6:    v = 64'h1f83d9abfb41bd6b;
            3'd7:    v = 64'h5be0cd19137e2179;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] round_k(input logic [6:0] r);
        logic [63:0] k;
        case (r)
            7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

// File: rtl/sha512_hash_engine_top.sv
// sha512_hash_engine_top: streaming sha-512 engine built around two small memories
// block word memory, hash state memory, round datapath and padding sequencer
// depends on sha512_pkg
//
// Message words enter one request at a time on the slave stream; a word that
// does not complete a 128-byte block is stored and leaves the engine ready. The
// sixteenth word starts a compression that runs as a sequence over the hash
// state memory: the eight state words are read into the working registers, 80
// rounds run on them (rounds 0-15 read the block memory, later rounds use a
// 16-entry schedule window), and the result is added back into the memory. A
// word with tlast set starts the closing sequence: the pad word(s), zero fill
// and two length words are pushed one per cycle, with a step that pushes
// nothing ahead of the length words, and with one or two compressions in
// between; then the eight digest words are shown in order. The engine takes
// no new word until the last digest word has been taken; it then starts over
// from the standard initial hash values. The hash state memory needs no
// clearing pass: an entry that has not been written since the last digest
// reads as its initial value.

module sha512_hash_engine_top
    import sha512_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // slave stream: message words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [63:0] msg_word, [67:64] valid_bytes, [71:68] zero
    input  logic        s_tlast,   // last_word
    // master stream: digest words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] digest_index
    output logic        m_tlast    // digest_last
);

    // memories
    logic [WORD_W-1:0] blk_mem  [BLK_DEPTH];
    logic [WORD_W-1:0] hash_mem [HASH_DEPTH];

    // control registers
    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic [3:0]        wc_reg, wc_next;
    logic [63:0]       bc_reg, bc_next;
    logic [2:0]        pad_nb_reg, pad_nb_next;
    logic [63:0]       msg_reg, msg_next;
    logic [2:0]        out_idx_reg, out_idx_next;
    logic [7:0]        hvalid_reg, hvalid_next;
    logic              rd_out_reg;

    // datapath registers
    logic [63:0]       wk_reg  [8];
    logic [63:0]       wk_next [8];
    logic [63:0]       win_reg  [16];
    logic [63:0]       win_next [16];
    logic [63:0]       wpre_reg;

    // memory read side
    logic [2:0]        hash_raddr, hash_raddr_reg;
    logic [63:0]       hash_q_reg;
    logic              hvalid_q_reg;
    logic [63:0]       hval;
    logic [3:0]        blk_raddr;
    logic [63:0]       blk_q_reg;

    // memory write side
    logic              hash_we;
    logic [2:0]        hash_waddr;
    logic [63:0]       hash_wdata;
    logic              push_en;
    logic [63:0]       push_data;

    // input fields
    logic [63:0]       in_msg;
    logic [NB_W-1:0]   in_nb, in_nb_sat;

    // round signals
    logic [6:0]        cnt_inc, cnt_dec;
    logic [63:0]       wr, t1, t2, ch, mj;

    assign in_msg    = s_tdata[63:0];
    assign in_nb     = s_tdata[67:64];
    assign in_nb_sat = (in_nb > FULL_BYTES) ? FULL_BYTES : in_nb;
    assign cnt_inc   = cnt_reg + 7'd1;
    assign cnt_dec   = cnt_reg - 7'd1;

    // unwritten state entries read as the initial hash values
    assign hval = hvalid_q_reg ? hash_q_reg : init_h(hash_raddr_reg);

    // stream outputs
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT) && rd_out_reg && (hash_raddr_reg == out_idx_reg);
    assign m_tdata  = hval;
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = (out_idx_reg == LAST_IDX);

    // one sha-512 round on the working registers
    assign wr = (cnt_reg < 7'd16) ? blk_q_reg : wpre_reg;
    assign ch = (wk_reg[4] & wk_reg[5]) ^ (~wk_reg[4] & wk_reg[6]);
    assign mj = (wk_reg[0] & wk_reg[1]) ^ (wk_reg[0] & wk_reg[2]) ^ (wk_reg[1] & wk_reg[2]);
    assign t1 = wk_reg[7] + big_sigma1(wk_reg[4]) + ch + round_k(cnt_reg) + wr;
    assign t2 = big_sigma0(wk_reg[0]) + mj;

    // block memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (push_en) begin
            blk_mem[wc_reg] <= push_data;
        end
        blk_q_reg <= blk_mem[blk_raddr];
    end

    // hash state memory: one write, one registered read; fold never reads
    // the entry it writes in the same cycle
    always_ff @(posedge aclk) begin
        if (hash_we) begin
            hash_mem[hash_waddr] <= hash_wdata;
        end
        hash_q_reg     <= hash_mem[hash_raddr];
        hash_raddr_reg <= hash_raddr;
    end

    // next state, memory controls and datapath updates
    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        wc_next      = wc_reg;
        bc_next      = bc_reg;
        pad_nb_next  = pad_nb_reg;
        msg_next     = msg_reg;
        out_idx_next = out_idx_reg;
        hvalid_next  = hvalid_reg;
        wk_next      = wk_reg;
        win_next     = win_reg;
        push_en      = 1'b0;
        push_data    = '0;
        hash_we      = 1'b0;
        hash_waddr   = cnt_dec[2:0];
        hash_wdata   = hval + wk_reg[0];
        hash_raddr   = '0;
        blk_raddr    = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (!s_tlast) begin
                        push_en   = 1'b1;
                        push_data = in_msg;
                        bc_next   = bc_reg + 64'd8;
                    end else begin
                        bc_next     = bc_reg + {60'd0, in_nb_sat};
                        msg_next    = in_msg;
                        pad_nb_next = in_nb_sat[2:0];
                        phase_next  = (in_nb_sat == FULL_BYTES) ? PH_MSG : PH_MARK;
                        state_next  = ST_PAD;
                    end
                end
            end

            // closing sequence, one pushed word per cycle but none just before the length words
            ST_PAD: begin
                case (phase_reg)
                    PH_MSG: begin
                        push_en     = 1'b1;
                        push_data   = msg_reg;
                        pad_nb_next = '0;
                        phase_next  = PH_MARK;
                    end
                    PH_MARK: begin
                        push_en    = 1'b1;
                        push_data  = mark_word(msg_reg, pad_nb_reg);
                        phase_next = PH_ZERO;
                    end
                    PH_ZERO: begin
                        if (wc_reg == LEN_SLOT) begin
                            phase_next = PH_LEN_HI;
                        end else begin
                            push_en = 1'b1;
                        end
                    end
                    PH_LEN_HI: begin
                        push_en    = 1'b1;
                        push_data  = {61'd0, bc_reg[63:61]};
                        phase_next = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        push_en    = 1'b1;
                        push_data  = {bc_reg[60:0], 3'b000};
                        phase_next = PH_DONE;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            // read the eight state words into the working registers
            ST_LOAD: begin
                hash_raddr = cnt_reg[2:0];
                if (cnt_reg != '0) begin
                    for (int i = 0; i < 7; i++) begin
                        wk_next[i] = wk_reg[i+1];
                    end
                    wk_next[7] = hval;
                end
                if (cnt_reg == LOAD_END) begin
                    state_next = ST_ROUND;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_inc;
                end
            end

            // one round per cycle, block word for the next round read ahead on the registered port
            ST_ROUND: begin
                blk_raddr = cnt_inc[3:0];
                for (int i = 7; i > 0; i--) begin
                    wk_next[i] = wk_reg[i-1];
                end
                wk_next[4] = wk_reg[3] + t1;
                wk_next[0] = t1 + t2;
                for (int i = 0; i < 15; i++) begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[15] = wr;
                if (cnt_reg == LAST_ROUND) begin
                    state_next = ST_FOLD;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_inc;
                end
            end

            // add the working registers back into the state memory
            ST_FOLD: begin
                hash_raddr = cnt_reg[2:0];
                if (cnt_reg != '0) begin
                    hash_we                  = 1'b1;
                    hvalid_next[cnt_dec[2:0]] = 1'b1;
                    for (int i = 0; i < 7; i++) begin
                        wk_next[i] = wk_reg[i+1];
                    end
                end
                if (cnt_reg == LOAD_END) begin
                    cnt_next = '0;
                    if (phase_reg == PH_DONE) begin
                        state_next   = ST_OUT;
                        out_idx_next = '0;
                    end else if (phase_reg == PH_NONE) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_PAD;
                    end
                end else begin
                    cnt_next = cnt_inc;
                end
            end

            // digest words straight from the state memory read port
            ST_OUT: begin
                hash_raddr = out_idx_reg;
                if (m_tvalid && m_tready) begin
                    if (out_idx_reg == LAST_IDX) begin
                        state_next  = ST_IDLE;
                        phase_next  = PH_NONE;
                        hvalid_next = '0;
                        bc_next     = '0;
                        wc_next     = '0;
                    end else begin
                        out_idx_next = out_idx_reg + 3'd1;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a push into the last slot of the block starts a compression
        if (push_en) begin
            wc_next = wc_reg + 4'd1;
            if (&wc_reg) begin
                state_next = ST_LOAD;
                cnt_next   = '0;
            end
        end
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_NONE;
            cnt_reg     <= '0;
            wc_reg      <= '0;
            bc_reg      <= '0;
            out_idx_reg <= '0;
            hvalid_reg  <= '0;
            hvalid_q_reg <= 1'b0;
            rd_out_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            wc_reg      <= wc_next;
            bc_reg      <= bc_next;
            out_idx_reg <= out_idx_next;
            hvalid_reg  <= hvalid_next;
            hvalid_q_reg <= hvalid_reg[hash_raddr];
            rd_out_reg  <= (state_reg == ST_OUT);
        end
    end

    // payload registers and next schedule word
    always_ff @(posedge aclk) begin
        msg_reg    <= msg_next;
        pad_nb_reg <= pad_nb_next;
        wk_reg     <= wk_next;
        win_reg    <= win_next;
        wpre_reg   <= small_sigma1(win_reg[15]) + win_reg[10]
                    + small_sigma0(win_reg[2]) + win_reg[1];
    end

endmodule

// File: rtl/sha512_checker.sv
// sha512_checker: port-level assertions for the sha-512 engine
// watches only the top-level stream ports; bound to sha512_hash_engine_top
// depends on nothing beyond the top-level port list

module sha512_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled digest request holds its word and index
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled digest request changed");

    // no message request is taken while digest words are pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready during digest output");

    // the last flag marks exactly the eighth digest word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == 3'd7)))
        else $error("digest last flag does not match index");

    // a last message word always starts the busy closing sequence
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready && !m_tvalid)
        else $error("engine idle right after last word");

    // after the final digest word the engine returns to taking input
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
        else $error("engine did not return to idle after digest");

endmodule

bind sha512_hash_engine_top sha512_checker u_sha512_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
